// ===== rtl/core/arctangent_poly_approx_macros.svh =====
// ----------------------------------------------------------------------------
// arctangent_poly_approx_macros
// Assertion macros for the arctangent block.
// ----------------------------------------------------------------------------
`ifndef ARCTANGENT_POLY_APPROX_MACROS_SVH
`define ARCTANGENT_POLY_APPROX_MACROS_SVH
`ifndef ASSERT_OFF
`define ATAN_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("assertion failed");
`define ATAN_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define ATAN_ASSERT(lbl, clk, rst, prop)
`define ATAN_ASSERT_RST(lbl, clk, prop)
`endif
`endif

// ===== rtl/core/atan_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atan_pkg
// Shared constants and types of the arctangent block.
// ----------------------------------------------------------------------------
package atan_pkg;
  localparam int QF = 30;
  localparam int IN_FRAC_DEF = 16;
  localparam int OUT_FRAC_DEF = 16;
  localparam logic signed [63:0] PI4_Q30 = 64'sd843314857;
  localparam logic signed [63:0] QONE = 64'sd1 << QF;

  // Horner coefficients, highest power first, Q30, rounded to nearest.
  function automatic logic signed [31:0] coef(input logic [2:0] k);
    logic signed [31:0] c;
    case (k)
      3'd0: c = 32'sd3077586;
      3'd1: c = -32'sd17357828;
      3'd2: c = 32'sd46073847;
      3'd3: c = -32'sd80841635;
      3'd4: c = 32'sd114420763;
      3'd5: c = -32'sd152566896;
      3'd6: c = 32'sd214679118;
      default: c = -32'sd357911922;
    endcase
    return c;
  endfunction

  // Item classified by the front end.
  typedef struct packed {
    logic        zero;
    logic        neg;
    logic        tneg;
    logic [32:0] num;
    logic [32:0] den;
  } front_t;
endpackage

// ===== rtl/core/atan_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atan_front
// Accepts the argument, takes its magnitude and forms numerator/denominator.
// ----------------------------------------------------------------------------
module atan_front #(
  parameter int IN_FRAC_BITS = atan_pkg::IN_FRAC_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [31:0]          value_in,
  output logic                 q_valid,
  input  logic                 q_stall,
  output atan_pkg::front_t     q_data
);
  logic [32:0] mag;
  logic [32:0] one;
  atan_pkg::front_t cls;

  assign one = 33'd1 << IN_FRAC_BITS;
  assign mag = value_in[31] ? (33'h100000000 - {1'b0, value_in}) : {1'b0, value_in};

  always_comb begin
    cls.zero = (value_in == 32'd0);
    cls.neg  = value_in[31];
    cls.tneg = mag < one;
    cls.num  = cls.tneg ? (one - mag) : (mag - one);
    cls.den  = mag + one;
  end

  assign in_stall = q_valid && q_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!in_stall) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      q_data <= cls;
    end
  end
endmodule

// ===== rtl/core/atan_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atan_fifo
// Two-entry queue between front and back; full throughput, registered stall.
// ----------------------------------------------------------------------------
module atan_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_stall,
  input  atan_pkg::front_t wr_data,
  output logic             rd_valid,
  input  logic             rd_stall,
  output atan_pkg::front_t rd_data
);
  atan_pkg::front_t mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       do_wr;
  logic       do_rd;

  assign wr_stall = (cnt == 2'd2);
  assign rd_valid = (cnt != 2'd0);
  assign rd_data  = mem[rp];
  assign do_wr    = wr_valid && !wr_stall;
  assign do_rd    = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_wr) wp <= ~wp;
      if (do_rd) rp <= ~rp;
      cnt <= cnt + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wp] <= wr_data;
  end
endmodule

// ===== rtl/core/atan_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atan_back
// Pipelined divider (one quotient bit per stage) and Horner pipeline.
// ----------------------------------------------------------------------------
module atan_back #(
  parameter int OUT_FRAC_BITS = atan_pkg::OUT_FRAC_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  atan_pkg::front_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [17:0]      angle_out
);
  // Quotient num*2^30/den < 2^30 (num < den), 31 bits incl. a rounding bit.
  localparam int QB = atan_pkg::QF + 1;
  // Horner: 10 multiplies, each two stages (product, round+add).
  localparam int NMUL = 10;

  logic adv;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  // ---------------- divider ----------------
  logic [QB:0]  vld;
  logic [33:0]  rem [QB+1];
  logic [32:0]  dd  [QB+1];
  logic [QB-1:0] qq [QB+1];
  logic         zz  [QB+1];
  logic         ng  [QB+1];
  logic         tn  [QB+1];

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (adv) vld[0] <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0] <= {1'b0, in_data.num};
      dd[0]  <= in_data.den;
      qq[0]  <= '0;
      zz[0]  <= in_data.zero;
      ng[0]  <= in_data.neg;
      tn[0]  <= in_data.tneg;
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_div
    logic [34:0] sh;
    logic [34:0] df;
    assign sh = {rem[s], 1'b0};
    assign df = sh - {2'b0, dd[s]};
    always_ff @(posedge clk) begin
      if (rst) vld[s+1] <= 1'b0;
      else if (adv) vld[s+1] <= vld[s];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem[s+1] <= df[34] ? sh[33:0] : df[33:0];
        qq[s+1]  <= {qq[s][QB-2:0], ~df[34]};
        dd[s+1]  <= dd[s];
        zz[s+1]  <= zz[s];
        ng[s+1]  <= ng[s];
        tn[s+1]  <= tn[s];
      end
    end
  end

  // round: quotient of 2^31 scale; rounded Q30 = (q+1)>>1
  logic [QB-1:0] qr;
  logic signed [63:0] t0;
  assign qr = qq[QB] + {{(QB-1){1'b0}}, 1'b1};
  assign t0 = tn[QB] ? -$signed({34'd0, qr[QB-1:1]}) : $signed({34'd0, qr[QB-1:1]});

  // ---------------- Horner ----------------
  // Ops in order: y=t*t; p=c0; p=p*y+c[k] k=1..7; p=p*y+1; r=p*t+pi/4
  typedef struct packed {
    logic               v;
    logic               z;
    logic               n;
    logic signed [31:0] t;
    logic signed [31:0] y;
    logic signed [31:0] p;
  } hs_t;

  hs_t hs [NMUL+1];
  logic [63:0] pm [NMUL];
  logic        pn [NMUL];
  hs_t hm [NMUL];

  always_ff @(posedge clk) begin
    if (rst) hs[0].v <= 1'b0;
    else if (adv) hs[0].v <= vld[QB];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      hs[0].z <= zz[QB];
      hs[0].n <= ng[QB];
      hs[0].t <= t0[31:0];
      hs[0].y <= '0;
      hs[0].p <= atan_pkg::coef(3'd0);
    end
  end

  for (genvar m = 0; m < NMUL; m++) begin : g_mul
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic [31:0] ma;
    logic [31:0] mb;
    logic signed [63:0] rr;
    logic signed [63:0] addc;
    logic [63:0] rnd;
    if (m == 0) begin : g_sq
      assign a = hs[m].t;
      assign b = hs[m].t;
    end else if (m == NMUL - 1) begin : g_fin
      assign a = hs[m].p;
      assign b = hs[m].t;
    end else begin : g_hor
      assign a = hs[m].p;
      assign b = hs[m].y;
    end
    assign ma = a[31] ? 32'(-a) : 32'(a);
    assign mb = b[31] ? 32'(-b) : 32'(b);
    always_ff @(posedge clk) begin
      if (rst) hm[m].v <= 1'b0;
      else if (adv) hm[m].v <= hs[m].v;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        pm[m] <= {32'd0, ma} * {32'd0, mb};
        pn[m] <= a[31] ^ b[31];
        hm[m].z <= hs[m].z;
        hm[m].n <= hs[m].n;
        hm[m].t <= hs[m].t;
        hm[m].y <= hs[m].y;
        hm[m].p <= hs[m].p;
      end
    end
    assign rnd = (pm[m] + (64'd1 << (atan_pkg::QF - 1))) >> atan_pkg::QF;
    assign rr = pn[m] ? -$signed(rnd) : $signed(rnd);
    if (m == 0) begin : g_a0
      assign addc = 64'sd0;
    end else if (m < NMUL - 2) begin : g_ak
      assign addc = 64'(atan_pkg::coef(3'(m)));
    end else if (m == NMUL - 2) begin : g_a1
      assign addc = atan_pkg::QONE;
    end else begin : g_ap
      assign addc = atan_pkg::PI4_Q30;
    end
    always_ff @(posedge clk) begin
      if (rst) hs[m+1].v <= 1'b0;
      else if (adv) hs[m+1].v <= hm[m].v;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        hs[m+1].z <= hm[m].z;
        hs[m+1].n <= hm[m].n;
        hs[m+1].t <= hm[m].t;
        if (m == 0) begin
          hs[m+1].y <= rr[31:0];
          hs[m+1].p <= hm[m].p;
        end else begin
          hs[m+1].y <= hm[m].y;
          hs[m+1].p <= 32'(rr + addc);
        end
      end
    end
  end

  // ---------------- output conversion ----------------
  localparam int SH = atan_pkg::QF - OUT_FRAC_BITS;
  logic signed [31:0] r;
  logic [31:0] rc;
  logic [31:0] rm;
  logic [17:0] o;
  assign r  = hs[NMUL].p;
  assign rc = r[31] ? 32'd0 : r;
  assign rm = (rc + (32'd1 << (SH - 1))) >> SH;
  assign o  = (rm > 32'd131071) ? 18'd131071 : rm[17:0];

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= hs[NMUL].v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      angle_out <= hs[NMUL].z ? 18'd0 : (hs[NMUL].n ? 18'(-o) : o);
    end
  end
endmodule

// ===== rtl/core/arctangent_poly_approx.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arctangent_poly_approx
// Fixed-point arctangent by the degree-17 odd polynomial after t=(a-1)/(a+1).
// ----------------------------------------------------------------------------
// Takes one signed argument per transaction (IN_FRAC_BITS fraction bits) and
// returns atan in radians (OUT_FRAC_BITS fraction bits), one result for each
// argument. Throughput is one transaction per cycle while the output is not held.
// The path: a front register, a two-entry queue, a 31-stage restoring divider
// (one quotient bit per stage), ten two-stage 32x32 multiply/round stages of
// the Horner chain, and the output register. The back end stalls as a whole when
// its output is held; the queue lets the front keep taking transactions until full.
`include "arctangent_poly_approx_macros.svh"
module arctangent_poly_approx #(
  parameter int IN_FRAC_BITS  = atan_pkg::IN_FRAC_DEF,
  parameter int OUT_FRAC_BITS = atan_pkg::OUT_FRAC_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] value_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [17:0] angle_out
);
  // front -> queue
  logic             f_valid;
  logic             f_stall;
  atan_pkg::front_t f_data;
  // queue -> back
  logic             b_valid;
  logic             b_stall;
  atan_pkg::front_t b_data;

  atan_front #(.IN_FRAC_BITS(IN_FRAC_BITS)) u_front (
    .clk, .rst, .in_valid, .in_stall, .value_in,
    .q_valid(f_valid), .q_stall(f_stall), .q_data(f_data)
  );

  atan_fifo u_fifo (
    .clk, .rst,
    .wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_data),
    .rd_valid(b_valid), .rd_stall(b_stall), .rd_data(b_data)
  );

  atan_back #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_back (
    .clk, .rst,
    .in_valid(b_valid), .in_stall(b_stall), .in_data(b_data),
    .out_valid, .out_stall, .angle_out
  );

  // A held result must not change.
  `ATAN_ASSERT(a_hold, clk, rst, (out_valid && out_stall) |=> (out_valid && $stable(angle_out)))
  // Zero angle only for tiny or zero arguments is not checked; magnitude bounded.
  `ATAN_ASSERT(a_range, clk, rst, out_valid |-> ($signed(angle_out) >= -18'sd131071))
  // Back end stalls exactly when the output is held.
  `ATAN_ASSERT(a_bstall, clk, rst, b_stall == (out_valid && out_stall))
  // Out of reset nothing is valid.
  `ATAN_ASSERT_RST(a_rst, clk, $past(rst) |-> !out_valid)
endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for arctangent_poly_approx.
// ----------------------------------------------------------------------------
// Arguments are queued by an initial block and sent by a bursty driver. A
// bit-exact Q30 arctangent model predicts each angle when its transaction is
// accepted, and a monitor behind a patterned stall checks the angles in order.
// ----------------------------------------------------------------------------
module tb;
  localparam int LATENCY = 80;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int N_RANDOM = 1930;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] value_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [17:0] angle_out;

  arctangent_poly_approx dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .value_in(value_in),
    .out_valid(out_valid), .out_stall(out_stall), .angle_out(angle_out)
  );

  logic [31:0] arg_queue[$];
  logic [17:0] angle_queue[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int idle_cycles = 0;
  bit hold_sender = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_phase = 0;

  initial forever #5 clk = ~clk;

  // Q30 x Q30, rounded to nearest with ties away from zero.
  function automatic longint q30_mul(longint x, longint y);
    longint unsigned mx, my, m;
    bit neg;
    neg = (x < 0) != (y < 0);
    mx = x < 0 ? -x : x;
    my = y < 0 ? -y : y;
    m = (mx * my + (64'd1 << (atan_pkg::QF - 1))) >> atan_pkg::QF;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [17:0] atan_angle(logic [31:0] arg);
    longint unsigned mag, unity, num, den, tm, rm;
    longint t, y, p, r, o;
    longint coeffs[8];
    bit neg, tneg;
    // Horner coefficients, highest power first, Q30
    coeffs = '{64'sd3077586, -64'sd17357828, 64'sd46073847, -64'sd80841635,
               64'sd114420763, -64'sd152566896, 64'sd214679118, -64'sd357911922};
    if (arg == 32'd0) return 18'd0;
    neg = arg[31];
    // most negative argument keeps its full 2^31 magnitude
    mag = neg ? (64'h1_0000_0000 - {32'd0, arg}) : {32'd0, arg};
    unity = 64'd1 << atan_pkg::IN_FRAC_DEF;
    den = mag + unity;
    tneg = mag < unity;
    num = tneg ? unity - mag : mag - unity;
    tm = ((num << atan_pkg::QF) + (den >> 1)) / den;
    t = tneg ? -longint'(tm) : longint'(tm);
    y = q30_mul(t, t);
    p = coeffs[0];
    for (int k = 1; k < 8; k++) p = q30_mul(p, y) + coeffs[k];
    p = q30_mul(p, y) + atan_pkg::QONE;
    r = q30_mul(p, t) + atan_pkg::PI4_Q30;
    if (r < 0) r = 0;  // tiny magnitudes can dip below zero
    rm = (longint'(r) + (64'd1 << (atan_pkg::QF - atan_pkg::OUT_FRAC_DEF - 1)))
         >> (atan_pkg::QF - atan_pkg::OUT_FRAC_DEF);
    o = longint'(rm);
    if (o > 131071) o = 131071;
    if (neg) o = -o;
    return o[17:0];
  endfunction

  task automatic report_mismatch(string what, logic [17:0] got, logic [17:0] want);
    $display("mismatch %s: angle_out got %h expected %h", what, got, want);
    errors++;
  endtask

  // Driver: bursts of random length separated by random gaps. valid only
  // drops when a transaction completes and no next one is launched.
  always @(posedge clk) begin
    bit fire;
    if (!rst) begin
      fire = in_valid && !in_stall;
      if (fire) begin
        angle_queue.push_back(atan_angle(value_in));
        n_sent++;
      end
      if (in_valid && !fire) begin
        // stalled: payload holds
      end else if (hold_sender || arg_queue.size() == 0) begin
        in_valid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        value_in <= arg_queue.pop_front();
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(40, 1);
          gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
        end
      end
    end
  end

  // Receiver stall pattern: runs of open and stalled cycles of random length.
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (stall_phase > 0) stall_phase--;
    else begin
      stall_phase = $urandom_range(30, 0);
      out_stall <= ($urandom_range(2, 0) == 0);
    end
  end

  // Monitor and watchdog
  always @(posedge clk) begin
    logic [17:0] want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (angle_queue.size() == 0) begin
          $display("unexpected transaction: angle_out %h", angle_out);
          errors++;
        end else begin
          want = angle_queue.pop_front();
          if (angle_out !== want) report_mismatch("angle", angle_out, want);
          n_checked++;
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)
          || (!in_valid && angle_queue.size() == 0)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired, %0d angles outstanding", angle_queue.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic logic [31:0] random_arg();
    case ($urandom_range(5, 0))
      0: return $urandom();
      1: return $urandom_range(32'h0002_0000, 0);                   // near +-1
      2: return -$urandom_range(32'h0002_0000, 0);
      3: return $urandom_range(255, 0) ^ {32{$urandom_range(1, 0) == 1}}; // tiny
      4: return 32'h1 << $urandom_range(31, 0);
      default: return $urandom() >> $urandom_range(31, 0);
    endcase
  endfunction

  initial begin
    logic [31:0] directed[$];
    directed = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'h0000_FFFF,
                 32'h0001_0001, 32'h0000_8000, 32'hFFFF_8000, 32'h0002_0000,
                 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0002, 32'hFFFF_FFFE,
                 32'h0064_0000, 32'hFF9C_0000, 32'h0000_0010};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) arg_queue.push_back(directed[i]);
    for (int i = 0; i < N_RANDOM / 2; i++) arg_queue.push_back(random_arg());
    wait (arg_queue.size() == 0 && !in_valid);
    // sender holds off until the pipeline has drained
    hold_sender = 1'b1;
    wait (angle_queue.size() == 0);
    repeat (20) @(posedge clk);
    for (int i = 0; i < N_RANDOM - N_RANDOM / 2; i++) arg_queue.push_back(random_arg());
    hold_sender = 1'b0;
    wait (arg_queue.size() == 0 && !in_valid);
    wait (angle_queue.size() == 0);
    repeat (LATENCY) @(posedge clk);
    $display("covered %0d arguments (signed extremes, +-1, tiny, powers of two, random)",
             n_sent);
    $display("checked %0d angles with bursty input and patterned output stall", n_checked);
    if (errors == 0 && angle_queue.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
